/* rtl/salc_pkg.sv */
package salc_pkg;

  // Cache geometry
  localparam int unsigned WAYS      = 4;
  localparam int unsigned SETS      = 64;
  localparam int unsigned ADDR_BITS = 32;

  localparam int unsigned WAY_W  = 2;
  localparam int unsigned RANK_W = 2;
  localparam int unsigned SET_W  = $clog2(SETS);
  localparam int unsigned LINE_W = ADDR_BITS;
  localparam int unsigned OFS_W  = 4;

  localparam logic [OFS_W-1:0] OFS_RESET = OFS_W'(5);

  // Access kinds
  localparam logic KIND_READ  = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [31:0] address;
  } in_item_t;

  typedef struct packed {
    logic             hit;
    logic [WAY_W-1:0] way_used;
    logic             writeback_valid;
    logic [31:0]      writeback_address;
  } out_item_t;

  // One memory row holds everything of a set except the valid bits
  typedef struct packed {
    logic [WAYS-1:0][LINE_W-1:0] tag;
    logic [WAYS-1:0]             dirty;
    logic [WAYS-1:0][RANK_W-1:0] rank;
  } row_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_UPDATE
  } state_e;

  typedef struct packed {
    logic accept;  // capture transaction, launch row read
    logic decide;  // compare tags, pick way and victim
    logic commit;  // write row and valid bit, load result
  } cmd_t;

endpackage

/* rtl/salc_ctrl.sv */
module salc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output salc_pkg::cmd_t cmd_o
);
  import salc_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  // State and result-valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        cmd_o.decide = 1'b1;
        state_d      = ST_UPDATE;
      end
      ST_UPDATE: begin
        // wait until the result register is free
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

/* rtl/salc_dp.sv */
module salc_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [salc_pkg::OFS_W-1:0]  cfg_wdata_i,
  input  salc_pkg::in_item_t          in_data_i,
  input  salc_pkg::cmd_t              cmd_i,
  output salc_pkg::out_item_t         out_data_o
);
  import salc_pkg::*;

  logic [OFS_W-1:0]  offset_q;
  logic              kind_q;
  logic [LINE_W-1:0] line_q;
  logic [SET_W-1:0]  set_q;
  logic [LINE_W-1:0] line_in;
  logic [SET_W-1:0]  set_in;

  row_t              mem_q [SETS];
  row_t              row_q;
  row_t              row_new;
  logic [WAYS-1:0]   valid_q [SETS];

  logic [WAYS-1:0]             vld;
  logic                        live;
  logic [WAYS-1:0]             eff_dirty;
  logic [WAYS-1:0][RANK_W-1:0] eff_rank;

  logic              found;
  logic              have_inv;
  logic [WAY_W-1:0]  hit_way;
  logic [WAY_W-1:0]  inv_way;
  logic [WAY_W-1:0]  lru_way;
  logic [WAY_W-1:0]  victim;

  logic              hit_q;
  logic [WAY_W-1:0]  way_q;
  logic              wb_valid_q;
  logic [LINE_W-1:0] victim_tag_q;
  logic [RANK_W-1:0] old_rank;

  out_item_t         out_q;

  // Line offset register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= OFS_RESET;
    end else if (cfg_we_i) begin
      offset_q <= cfg_wdata_i;
    end
  end

  assign line_in = in_data_i.address >> offset_q;
  assign set_in  = line_in[SET_W-1:0];

  // Transaction capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      kind_q <= in_data_i.kind;
      line_q <= line_in;
      set_q  <= set_in;
    end
  end

  // Row memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      mem_q[set_q] <= row_new;
    end
    if (cmd_i.accept) begin
      row_q <= mem_q[set_in];
    end
  end

  // Valid bits, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < SETS; s++) begin
        valid_q[s] <= '0;
      end
    end else if (cmd_i.commit) begin
      valid_q[set_q][way_q] <= 1'b1;
    end
  end

  // A set with no valid way has never been written: use reset dirty and ranks
  assign vld  = valid_q[set_q];
  assign live = |vld;

  always_comb begin
    for (int i = 0; i < WAYS; i++) begin
      eff_dirty[i] = live ? row_q.dirty[i] : 1'b0;
      eff_rank[i]  = live ? row_q.rank[i] : RANK_W'(i);
    end
  end

  // Tag compare, invalid search and LRU search; highest way wins
  always_comb begin
    found    = 1'b0;
    have_inv = 1'b0;
    hit_way  = '0;
    inv_way  = '0;
    lru_way  = '0;
    for (int i = 0; i < WAYS; i++) begin
      if (vld[i] && (row_q.tag[i] == line_q)) begin
        found   = 1'b1;
        hit_way = WAY_W'(i);
      end
      if (!vld[i]) begin
        have_inv = 1'b1;
        inv_way  = WAY_W'(i);
      end
      if (eff_rank[i] == '0) begin
        lru_way = WAY_W'(i);
      end
    end
    victim = have_inv ? inv_way : lru_way;
  end

  // Decision registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.decide) begin
      hit_q        <= found;
      way_q        <= found ? hit_way : victim;
      wb_valid_q   <= !found && !have_inv && eff_dirty[victim];
      victim_tag_q <= row_q.tag[victim];
    end
  end

  // New row contents: fill, dirty update, LRU rank update
  assign old_rank = eff_rank[way_q];

  always_comb begin
    row_new.tag   = row_q.tag;
    row_new.dirty = eff_dirty;
    for (int i = 0; i < WAYS; i++) begin
      if (eff_rank[i] > old_rank) begin
        row_new.rank[i] = eff_rank[i] - RANK_W'(1);
      end else begin
        row_new.rank[i] = eff_rank[i];
      end
    end
    row_new.rank[way_q] = RANK_W'(WAYS - 1);
    if (!hit_q) begin
      row_new.tag[way_q]   = line_q;
      row_new.dirty[way_q] = 1'b0;
    end
    if (kind_q == KIND_WRITE) begin
      row_new.dirty[way_q] = 1'b1;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_q.hit               <= hit_q;
      out_q.way_used          <= way_q;
      out_q.writeback_valid   <= wb_valid_q;
      out_q.writeback_address <= wb_valid_q ? 32'(victim_tag_q << offset_q) : '0;
    end
  end

  assign out_data_o = out_q;

endmodule

/* rtl/set_assoc_lru_cache_tags_top.sv */
// Channel   Direction  Handshake               Payload
// cfg       in         cfg_we_i                cfg_wdata_i (line offset bits)
// in        in         in_valid_i / in_stall_o in_data_i (kind, address)
// out       out        out_valid_o/out_stall_i out_data_o (hit, way, write-back)
//
// Each transaction runs capture and row read, tag compare, then row write-back
// and result load in turn; the read-modify-write of the set row sets this order.
// Reset clears valid bits, state and the offset register (to 5) at once.
// A stalled result holds the final cycle until the result register frees;
// a new transaction is still taken while the previous result waits.
module set_assoc_lru_cache_tags_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [salc_pkg::OFS_W-1:0] cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  salc_pkg::in_item_t         in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output salc_pkg::out_item_t        out_data_o
);
  import salc_pkg::*;

  cmd_t cmd;

  salc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  salc_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .out_data_o  (out_data_o)
  );

endmodule

/* tb/tb_set_assoc_lru_cache_tags_top.sv */
module tb_set_assoc_lru_cache_tags_top;
  timeunit 1ns;
  timeprecision 1ps;

  import salc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned PHASE_ITEMS = 180;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [OFS_W-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_item_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_item_t out_data_o;

  set_assoc_lru_cache_tags_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always #1 clk_i = ~clk_i;

  // Shadow copy of the tag store
  logic [31:0]       tag_mem   [SETS][WAYS];
  bit                valid_mem [SETS][WAYS];
  bit                dirty_mem [SETS][WAYS];
  logic [RANK_W-1:0] rank_mem  [SETS][WAYS];
  logic [OFS_W-1:0]  line_ofs;

  in_item_t  access_queue[$];
  out_item_t pending_lookups[$];

  int unsigned issued_count = 0;
  int unsigned accepted_count = 0;
  int unsigned err_count = 0;
  int unsigned cycle_count = 0;
  bit          in_took = 1'b0;
  bit          in_busy = 1'b0;
  bit          out_busy = 1'b0;
  int unsigned in_gap = 0;
  int unsigned stall_left = 0;
  logic [OFS_W-1:0] cur_ofs = OFS_RESET;

  // Lookup, fill/evict and LRU update of one access; returns the result
  function automatic out_item_t lookup_and_update(in_item_t acc);
    logic [31:0]       line;
    int unsigned       set_idx;
    bit                found;
    bit                have_free;
    int unsigned       way;
    int unsigned       free_way;
    int unsigned       victim;
    logic [RANK_W-1:0] old_rank;
    out_item_t         res;
    line = acc.address >> line_ofs;
    set_idx = line % SETS;
    found = 1'b0;
    have_free = 1'b0;
    way = 0;
    free_way = 0;
    victim = 0;
    res = '0;
    // highest matching way wins, highest free way is filled first
    for (int i = 0; i < WAYS; i++) begin
      if (valid_mem[set_idx][i] && tag_mem[set_idx][i] == line) begin
        found = 1'b1;
        way = i;
      end
      if (!valid_mem[set_idx][i]) begin
        have_free = 1'b1;
        free_way = i;
      end
    end
    if (!found) begin
      if (have_free) begin
        victim = free_way;
      end else begin
        for (int i = 0; i < WAYS; i++) begin
          if (rank_mem[set_idx][i] == '0) victim = i;
        end
        if (dirty_mem[set_idx][victim]) begin
          res.writeback_valid = 1'b1;
          res.writeback_address = tag_mem[set_idx][victim] << line_ofs;
        end
      end
      tag_mem[set_idx][victim] = line;
      valid_mem[set_idx][victim] = 1'b1;
      dirty_mem[set_idx][victim] = 1'b0;
      way = victim;
    end
    if (acc.kind == KIND_WRITE) dirty_mem[set_idx][way] = 1'b1;
    // promote to most recently used
    old_rank = rank_mem[set_idx][way];
    for (int i = 0; i < WAYS; i++) begin
      if (rank_mem[set_idx][i] > old_rank) rank_mem[set_idx][i] = rank_mem[set_idx][i] - 1'b1;
    end
    rank_mem[set_idx][way] = RANK_W'(WAYS - 1);
    res.hit = found;
    res.way_used = WAY_W'(way);
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    err_count++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  function automatic int unsigned draw_gap(bit busy);
    int unsigned r;
    if (!busy) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic push_access(logic kind, logic [31:0] addr);
    in_item_t it;
    it.kind = kind;
    it.address = addr;
    access_queue = {access_queue, it};
    issued_count++;
  endtask

  // Byte address of line (tag, set) under the current offset
  function automatic logic [31:0] line_addr(logic [31:0] tag, int unsigned set_idx,
                                            logic [31:0] low);
    logic [31:0] line;
    logic [31:0] low_mask;
    line = (tag << SET_W) | set_idx;
    low_mask = (32'd1 << cur_ofs) - 32'd1;
    return (line << cur_ofs) | (low & low_mask);
  endfunction

  // Mostly a small pool of lines per set so that hits and evictions are common
  task automatic queue_random_accesses(int unsigned n);
    int unsigned set_pool[4];
    logic [31:0] tag_pool[6];
    int unsigned r;
    logic        kind;
    set_pool[0] = 0;
    set_pool[1] = SETS - 1;
    set_pool[2] = $urandom_range(0, SETS - 1);
    set_pool[3] = $urandom_range(0, SETS - 1);
    foreach (tag_pool[i]) tag_pool[i] = $urandom();
    tag_pool[0] = '0;
    for (int unsigned k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      kind = $urandom_range(0, 1) ? KIND_WRITE : KIND_READ;
      if (r < 72) begin
        push_access(kind, line_addr(tag_pool[$urandom_range(0, 5)],
                                    set_pool[$urandom_range(0, 3)], $urandom()));
      end else if (r < 94) begin
        push_access(kind, $urandom());
      end else if (r < 97) begin
        push_access(kind, 32'hFFFF_FFFF);
      end else begin
        push_access(kind, 32'h0000_0000);
      end
    end
  endtask

  task automatic wait_drained();
    while (accepted_count != issued_count || pending_lookups.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_offset(logic [OFS_W-1:0] value);
    wait_drained();
    repeat (4) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    cur_ofs = value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Input driver: payload only moves after acceptance or while idle
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_took)) begin
      if (in_gap != 0) begin
        in_gap--;
        in_valid_i <= 1'b0;
      end else if (access_queue.size() != 0) begin
        in_data_i <= access_queue.pop_front();
        in_valid_i <= 1'b1;
        in_gap = draw_gap(in_busy);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result side stall pattern
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (stall_left != 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
        stall_left = draw_gap(out_busy);
      end
    end
  end

  // Monitor: predict on accepted accesses, check accepted results
  always @(posedge clk_i) begin
    out_item_t want;
    in_took = 1'b0;
    if (rst_ni) begin
      if (cfg_we_i) line_ofs = cfg_wdata_i;
      if (in_valid_i && !in_stall_o) begin
        in_took = 1'b1;
        accepted_count++;
        pending_lookups = {pending_lookups, lookup_and_update(in_data_i)};
      end
      if (out_valid_o && !out_stall_i) begin
        if (pending_lookups.size() == 0) begin
          report_mismatch($sformatf("result with nothing outstanding: %h", out_data_o));
        end else begin
          want = pending_lookups.pop_front();
          if (out_data_o.hit !== want.hit)
            report_mismatch($sformatf("hit %b, want %b", out_data_o.hit, want.hit));
          if (out_data_o.way_used !== want.way_used)
            report_mismatch($sformatf("way_used %0d, want %0d",
                                      out_data_o.way_used, want.way_used));
          if (out_data_o.writeback_valid !== want.writeback_valid)
            report_mismatch($sformatf("writeback_valid %b, want %b",
                                      out_data_o.writeback_valid, want.writeback_valid));
          if (out_data_o.writeback_address !== want.writeback_address)
            report_mismatch($sformatf("writeback_address %h, want %h",
                                      out_data_o.writeback_address, want.writeback_address));
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_set_assoc_lru_cache_tags_top: FAIL");
      $finish;
    end
  end

  initial begin
    logic [OFS_W-1:0] ofs_plan[6];
    ofs_plan = '{4'd0, 4'd12, 4'd15, 4'd7, 4'd1, 4'd5};
    line_ofs = OFS_RESET;
    for (int s = 0; s < SETS; s++) begin
      for (int w = 0; w < WAYS; w++) begin
        tag_mem[s][w] = '0;
        valid_mem[s][w] = 1'b0;
        dirty_mem[s][w] = 1'b0;
        rank_mem[s][w] = RANK_W'(w);
      end
    end
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: address extremes, hits, dirty and clean evictions
    push_access(KIND_READ, 32'h0000_0000);
    push_access(KIND_WRITE, 32'hFFFF_FFFF);
    push_access(KIND_READ, 32'hFFFF_FFE0);
    push_access(KIND_WRITE, 32'h8000_0000);
    push_access(KIND_READ, 32'h0000_001F);
    // fill set 5 with written lines, then force dirty victims out
    for (int t = 1; t <= 4; t++) push_access(KIND_WRITE, line_addr(t, 5, 0));
    push_access(KIND_READ, line_addr(1, 5, 3));
    push_access(KIND_READ, line_addr(5, 5, 0));
    push_access(KIND_WRITE, line_addr(6, 5, 0));
    push_access(KIND_READ, line_addr(6, 5, 31));
    push_access(KIND_READ, line_addr(7, 5, 0));
    // fill set 9 with clean lines; the victim needs no write-back
    for (int t = 1; t <= 4; t++) push_access(KIND_READ, line_addr(t, 9, 0));
    push_access(KIND_READ, line_addr(5, 9, 0));
    push_access(KIND_WRITE, line_addr(2, 9, 0));
    push_access(KIND_READ, line_addr(6, 9, 0));
    push_access(KIND_READ, line_addr(7, 9, 0));

    // Random phases, each under its own line offset
    for (int p = 0; p < 6; p++) begin
      write_offset(ofs_plan[p]);
      @(posedge clk_i);
      in_busy = (p % 3) != 0;
      out_busy = (p % 2) == 0 || p == 5;
      queue_random_accesses(PHASE_ITEMS);
    end

    wait_drained();
    repeat (20) @(negedge clk_i);
    if (err_count == 0) begin
      $display("tb_set_assoc_lru_cache_tags_top: PASS");
    end else begin
      $display("tb_set_assoc_lru_cache_tags_top: FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/salc_pkg.sv
rtl/salc_ctrl.sv
rtl/salc_dp.sv
rtl/set_assoc_lru_cache_tags_top.sv
tb/tb_set_assoc_lru_cache_tags_top.sv
